[rtl/core/unique_id_set_with_compaction_defines.svh]
// Assertion macros for the unique ID set block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef UNIQUE_ID_SET_WITH_COMPACTION_DEFINES_SVH
`define UNIQUE_ID_SET_WITH_COMPACTION_DEFINES_SVH

`ifndef SYNTH

// Expression must hold at every clock edge outside reset
`define UISC_ASSERT(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// Antecedent implies consequent in the same cycle
`define UISC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Antecedent implies consequent in the next cycle
`define UISC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define UISC_ASSERT(name, clk, rst_n, expr)
`define UISC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define UISC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/uisc_pkg.sv]
// Shared types, codes and field widths for the unique ID set block.
// No dependencies; used by uisc_cell and the top level.
package uisc_pkg;

    // Default parameter values
    localparam int CAPACITY_DEF  = 64;
    localparam int CODE_BITS_DEF = 16;

    // Field widths on the stream ports
    localparam int OP_W        = 2;
    localparam int CODE_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int RESULT_W    = STATUS_W + 1 + POS_W + COUNT_W;
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Decoded request, broadcast to every cell while a search runs
    typedef struct packed {
        logic ins;
        logic del;
    } uisc_cmd_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic active;
        logic hit;
        logic ins;
    } uisc_probe_t;

endpackage

[rtl/core/uisc_cell.sv]
// One storage cell of the ID row: holds an entry, compares it against the
// passing search token and shifts or inserts. Depends on uisc_pkg.
module uisc_cell #(
    parameter int CAPACITY  = uisc_pkg::CAPACITY_DEF,
    parameter int CODE_BITS = uisc_pkg::CODE_BITS_DEF,
    parameter int IDX       = 0,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  uisc_pkg::uisc_cmd_t   cmd_i,
    input  logic [CODE_BITS-1:0]  key_i,
    input  logic [CNT_W-1:0]      count_i,
    input  uisc_pkg::uisc_probe_t probe_i,
    input  logic [IDX_W-1:0]      pos_i,
    input  logic [CODE_BITS-1:0]  right_entry_i,
    output logic [CODE_BITS-1:0]  entry_o,
    output uisc_pkg::uisc_probe_t probe_o,
    output logic [IDX_W-1:0]      pos_o
);
    import uisc_pkg::*;

    logic [CODE_BITS-1:0] entry_reg, entry_next;
    uisc_probe_t          probe_reg, probe_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;

    logic cell_valid;
    logic match;
    logic do_shift;
    logic do_ins;

    assign cell_valid = CNT_W'(IDX) < count_i;
    assign match      = probe_i.active & cell_valid & (entry_reg == key_i);
    // after a delete hit every later valid entry moves down one place
    assign do_shift   = probe_i.active & cmd_i.del & cell_valid & (probe_i.hit | match);
    // first free cell takes the key when nothing matched
    assign do_ins     = probe_i.active & cmd_i.ins & ~cell_valid & ~probe_i.hit & ~probe_i.ins;

    always_comb begin
        entry_next = entry_reg;
        if (do_shift) begin
            entry_next = right_entry_i;
        end else if (do_ins) begin
            entry_next = key_i;
        end
    end

    always_comb begin
        probe_next.active = probe_i.active;
        probe_next.hit    = probe_i.hit | match;
        probe_next.ins    = probe_i.ins | do_ins;
        pos_next          = (match | do_ins) ? IDX_W'(IDX) : pos_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        pos_reg   <= pos_next;
    end

    assign entry_o = entry_reg;
    assign probe_o = probe_reg;
    assign pos_o   = pos_reg;

endmodule

[rtl/core/unique_id_set_with_compaction.sv]
// Top level of the unique ID set: request decode, entry count, cell row
// and result register. Depends on uisc_pkg, uisc_cell and the defines header.
`include "unique_id_set_with_compaction_defines.svh"

// Ordered set of distinct ID codes held in a row of CAPACITY cells. A request
// (insert, delete, lookup) launches a search token that walks the row one cell
// per cycle; each cell compares its entry as the token passes, a delete moves
// later entries down one place behind the token, and an insert lands in the
// first free cell. The token passes start_reg and then each cell's register;
// when it leaves the last cell the result enters the output register. Only one
// request is in the row at a time: the next request is taken once its result
// has entered the output register. A finished result may wait in the output
// register while the next request is already being worked on; the result after
// it then waits in a spare register and no further request is taken until that
// one has moved on. Op code 3 is treated as lookup.
module unique_id_set_with_compaction #(
    parameter int CAPACITY  = uisc_pkg::CAPACITY_DEF,
    parameter int CODE_BITS = uisc_pkg::CODE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uisc_pkg::S_TDATA_W-1:0] s_tdata,   // code[15:0]
    input  logic [uisc_pkg::S_TUSER_W-1:0] s_tuser,   // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uisc_pkg::M_TDATA_W-1:0] m_tdata    // status[2:0], found[3],
                                                      // position[9:4], count[16:10]
);
    import uisc_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                 s_accept;
    logic                 m_accept;
    uisc_cmd_t            cmd_in;

    logic                 busy_reg, busy_next;
    uisc_probe_t          start_reg, start_next;
    uisc_cmd_t            cmd_reg;
    logic [CODE_BITS-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [M_TDATA_W-1:0] hold_data_reg, hold_data_next;

    logic [CODE_BITS-1:0] entry_q [CAPACITY];
    uisc_probe_t          probe_q [CAPACITY+1];
    logic [IDX_W-1:0]     pos_q   [CAPACITY+1];

    logic                 chain_done;
    uisc_probe_t          end_probe;
    logic [STATUS_W-1:0]  res_status;
    logic                 res_found;
    logic [IDX_W-1:0]     res_pos;
    logic [M_TDATA_W-1:0] res_word;

    assign s_tready = ~busy_reg;
    assign s_accept = s_tvalid & s_tready;
    assign m_accept = m_tvalid_reg & m_tready;

    always_comb begin
        cmd_in = '0;
        unique case (s_tuser)
            OP_INSERT: cmd_in.ins = 1'b1;
            OP_DELETE: cmd_in.del = 1'b1;
            default:   cmd_in     = '0;   // lookup, spare code included
        endcase
    end

    // ---- cell row ----
    assign probe_q[0] = start_reg;
    assign pos_q[0]   = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        uisc_cell #(
            .CAPACITY  (CAPACITY),
            .CODE_BITS (CODE_BITS),
            .IDX       (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd_i         (cmd_reg),
            .key_i         (key_reg),
            .count_i       (count_reg),
            .probe_i       (probe_q[i]),
            .pos_i         (pos_q[i]),
            .right_entry_i (entry_q[(i + 1 < CAPACITY) ? i + 1 : i]),
            .entry_o       (entry_q[i]),
            .probe_o       (probe_q[i+1]),
            .pos_o         (pos_q[i+1])
        );
    end

    assign end_probe  = probe_q[CAPACITY];
    assign chain_done = end_probe.active;

    // ---- result formation ----
    always_comb begin
        res_found  = end_probe.hit;
        res_pos    = pos_q[CAPACITY];
        count_next = count_reg;
        if (cmd_reg.ins) begin
            if (end_probe.ins) begin
                res_status = ST_INSERTED;
            end else if (end_probe.hit) begin
                res_status = ST_PRESENT;
            end else begin
                res_status = ST_FULL;
            end
        end else begin
            res_status = end_probe.hit ? ST_HIT : ST_MISS;
        end
        if (chain_done) begin
            if (cmd_reg.ins && end_probe.ins) begin
                count_next = count_reg + CNT_W'(1);
            end else if (cmd_reg.del && end_probe.hit) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    assign res_word = M_TDATA_W'({COUNT_W'(count_next), POS_W'(res_pos), res_found, res_status});

    // ---- control and output staging ----
    always_comb begin
        busy_next        = busy_reg;
        start_next       = '0;
        start_next.active = s_accept;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        hold_valid_next  = hold_valid_reg;
        hold_data_next   = hold_data_reg;

        if (m_accept) begin
            m_tvalid_next = 1'b0;
        end

        if (hold_valid_reg && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_next   = 1'b1;
            m_tdata_next    = hold_data_reg;
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end

        if (chain_done) begin
            if (!m_tvalid_reg || m_tready) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = res_word;
                busy_next     = 1'b0;
            end else begin
                hold_valid_next = 1'b1;
                hold_data_next  = res_word;
            end
        end

        if (s_accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            start_reg      <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            start_reg      <= start_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg   <= m_tdata_next;
        hold_data_reg <= hold_data_next;
        if (s_accept) begin
            cmd_reg <= cmd_in;
            key_reg <= CODE_BITS'(s_tdata[CODE_W-1:0]);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- checks ----
    `UISC_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `UISC_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_accept, busy_reg)
    `UISC_ASSERT_IMPL(a_done_busy, aclk, aresetn, chain_done, busy_reg)
    `UISC_ASSERT_IMPL(a_hold_behind_out, aclk, aresetn, hold_valid_reg, m_tvalid_reg && busy_reg)
    `UISC_ASSERT_NEXT(a_count_quiet, aclk, aresetn, !chain_done, $stable(count_reg))

endmodule
